// ----- rtl/core/dove_pkg.sv -----
// ----------------------------------------------------------------------------
// dove_pkg
// types and constants shared by the option value extractor
// ----------------------------------------------------------------------------
`default_nettype none

package dove_pkg;

    localparam logic [7:0] CODE_END       = 8'hFF;
    localparam logic [7:0] CODE_PAD       = 8'h00;
    localparam logic [7:0] WANTED_DEFAULT = 8'd15;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       first_byte;
        logic [9:0] options_len;
    } in_word_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       value_last;
    } out_word_t;

    // up to two result words produced by one input word, in order
    typedef struct packed {
        logic      v0;
        logic      v1;
        out_word_t w0;
        out_word_t w1;
    } push_t;

endpackage

`default_nettype wire

// ----- rtl/core/dove_front.sv -----
// ----------------------------------------------------------------------------
// dove_front
// option walker: takes one options byte a cycle while the queue has room for two words and pushes value words
// ----------------------------------------------------------------------------
`default_nettype none

module dove_front #(
    parameter int OPTIONS_MAX = 512
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire dove_pkg::in_word_t in_word,
    input  wire logic             cfg_valid,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             room_two,
    output dove_pkg::push_t       push
);
    import dove_pkg::*;

    localparam int LW = $clog2(OPTIONS_MAX + 1);
    localparam int SW = LW + 9;

    typedef enum logic [1:0] {
        PH_DONE,
        PH_CODE,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [LW-1:0]   pos_reg, pos_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            match_reg, match_next;
    logic [7:0]      rem_reg, rem_next;
    logic [7:0]      held_byte_reg, held_byte_next;
    logic            held_valid_reg, held_valid_next;
    logic [7:0]      wanted_reg;

    logic            accept;
    logic [31:0]     len_wide;
    logic [LW-1:0]   len_sat;

    assign in_stall = !room_two;
    assign accept   = in_valid && !in_stall;
    assign len_wide = 32'(in_word.options_len);
    assign len_sat  = (len_wide > 32'(OPTIONS_MAX)) ? LW'(OPTIONS_MAX) : LW'(len_wide);

    always_comb
    begin
        phase_t        ph;
        logic [LW-1:0] pos;
        logic [LW-1:0] len;
        logic          mt;
        logic [7:0]    rem;
        logic          hv;
        logic [7:0]    b;
        logic [SW-1:0] pos1;
        logic [7:0]    rem_dec;

        b   = in_word.opt_byte;
        ph  = phase_reg;
        pos = pos_reg;
        len = len_reg;
        mt  = match_reg;
        rem = rem_reg;
        hv  = held_valid_reg;
        if (in_word.first_byte)
        begin
            ph  = PH_CODE;
            pos = '0;
            len = len_sat;
            mt  = 1'b0;
            rem = '0;
            hv  = 1'b0;
        end
        pos1    = SW'(pos) + SW'(1);
        rem_dec = rem - 8'd1;

        phase_next      = phase_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        match_next      = match_reg;
        rem_next        = rem_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        push            = '0;

        if (accept)
        begin
            phase_next      = ph;
            pos_next        = pos;
            len_next        = len;
            match_next      = mt;
            rem_next        = rem;
            held_valid_next = hv;
            if (ph != PH_DONE)
            begin
                pos_next = pos + LW'(1);
                case (ph)
                    PH_CODE:
                    begin
                        if (pos1 >= SW'(len) || b == CODE_END)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (b != CODE_PAD)
                        begin
                            match_next = (b == wanted_reg);
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        if (pos1 + SW'(b) >= SW'(len))
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (b == 8'd0)
                        begin
                            phase_next = PH_CODE;
                        end
                        else
                        begin
                            rem_next   = b;
                            phase_next = PH_DATA;
                        end
                    end
                    default:
                    begin
                        rem_next = rem_dec;
                        if (mt)
                        begin
                            if (rem_dec != 8'd0)
                            begin
                                push.v0         = hv;
                                push.w0         = '{value_byte: held_byte_reg, value_last: 1'b0};
                                held_byte_next  = b;
                                held_valid_next = 1'b1;
                            end
                            else
                            begin
                                // trailing nul moves the last mark to the held byte
                                if (b == 8'd0)
                                begin
                                    push.v0 = hv;
                                    push.w0 = '{value_byte: held_byte_reg, value_last: 1'b1};
                                end
                                else if (hv)
                                begin
                                    push.v0 = 1'b1;
                                    push.w0 = '{value_byte: held_byte_reg, value_last: 1'b0};
                                    push.v1 = 1'b1;
                                    push.w1 = '{value_byte: b, value_last: 1'b1};
                                end
                                else
                                begin
                                    push.v0 = 1'b1;
                                    push.w0 = '{value_byte: b, value_last: 1'b1};
                                end
                                held_valid_next = 1'b0;
                            end
                        end
                        if (rem_dec == 8'd0)
                        begin
                            match_next = 1'b0;
                            phase_next = PH_CODE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DONE;
            pos_reg        <= '0;
            len_reg        <= '0;
            match_reg      <= 1'b0;
            rem_reg        <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            wanted_reg     <= WANTED_DEFAULT;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            match_reg      <= match_next;
            rem_reg        <= rem_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            if (cfg_valid)
            begin
                wanted_reg <= cfg_data;
            end
        end
    end

`ifndef SYNTH
    a_second_word_closes: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> (push.v0 && !push.w0.value_last && push.w1.value_last))
        else $error("second word pushed without an open first word");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dove_queue.sv -----
// ----------------------------------------------------------------------------
// dove_queue
// short queue between walker and output stage, two writes and one read a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dove_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dove_pkg::push_t   push,
    output logic                   room_two,
    input  wire logic              pop,
    output logic                   nonempty,
    output dove_pkg::out_word_t    head
);
    import dove_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    out_word_t     entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_push;

    assign n_push      = CW'(push.v0) + CW'(push.v1);
    assign wr_ptr_next = wr_ptr_reg + AW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + n_push - CW'(pop);
    assign room_two    = (count_reg <= CW'(DEPTH - 2));
    assign nonempty    = (count_reg != '0);
    assign head        = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            entry_reg[wr_ptr_reg] <= push.w0;
        end
        if (push.v1)
        begin
            entry_reg[wr_ptr_reg + AW'(1)] <= push.w1;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> room_two)
        else $error("queue written without room");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dove_back.sv -----
// ----------------------------------------------------------------------------
// dove_back
// output register, drains the queue one word a cycle toward the sink while out_stall is low
// ----------------------------------------------------------------------------
`default_nettype none

module dove_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                nonempty,
    input  wire dove_pkg::out_word_t head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output dove_pkg::out_word_t      out_word
);
    import dove_pkg::*;

    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      load;

    assign load      = !out_valid_reg || !out_stall;
    assign pop       = load && nonempty;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= nonempty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg <= head;
        end
    end

`ifndef SYNTH
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
        else $error("stalled output word dropped or changed");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dhcp_option_value_extractor.sv -----
// ----------------------------------------------------------------------------
// dhcp_option_value_extractor
// walks the options area a byte a word and emits the wanted option's value
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    in_word   (opt_byte, first_byte, options_len)
//  out      source     out_valid/out_stall  out_word  (value_byte, value_last)
//  cfg      sink       cfg_valid/cfg_ready  cfg_data  (wanted_option)
//
//  one input word a cycle while in_stall is low; a value word passes through the queue and then the output register
//  the walker pushes up to two words a cycle into a four-entry queue
//  in_stall rises while the queue has fewer than two free entries
//  reset leaves the walker waiting for a first byte and wanted_option at 15
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_option_value_extractor #(
    parameter int OPTIONS_MAX = 512
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire dove_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output dove_pkg::out_word_t      out_word,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);
    import dove_pkg::*;

    push_t     push;
    logic      room_two;
    logic      pop;
    logic      nonempty;
    out_word_t head;

    assign cfg_ready = 1'b1;

    dove_front #(
        .OPTIONS_MAX (OPTIONS_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .room_two  (room_two),
        .push      (push)
    );

    dove_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room_two (room_two),
        .pop      (pop),
        .nonempty (nonempty),
        .head     (head)
    );

    dove_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (nonempty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ----- tb/dhcp_option_value_extractor_test.sv -----
// ----------------------------------------------------------------------------
// dhcp_option_value_extractor_test
// self-checking bench for the dhcp option value extractor
//
// Byte streams of options areas are pushed through the input channel. Most
// are well-formed option lists that favor the wanted code, with trailing
// nul bytes, zero lengths and padding. The rest are cut-off or truncated
// areas, odd lengths and raw noise. A scoreboard walks every accepted word
// the way the block should and queues the value words it must emit. Each
// emitted word is then compared against that queue. The wanted code is
// rewritten between phases while the block is idle, and the sender and the
// receiver idle or stall at several rates.
// ----------------------------------------------------------------------------

class value_scoreboard;

    typedef enum logic [1:0] {WALK_DONE, WALK_CODE, WALK_LEN, WALK_DATA} walk_t;

    logic [7:0]              wanted;
    int unsigned             area_max;
    int unsigned             position;
    int unsigned             area_len;
    walk_t                   walk;
    bit                      matching;
    logic [7:0]              remaining;
    logic [7:0]              held;
    bit                      held_ok;
    dove_pkg::out_word_t     expected_values[$];
    int                      errors;

    function new(int unsigned max_len);
        area_max  = max_len;
        wanted    = dove_pkg::WANTED_DEFAULT;
        position  = 0;
        area_len  = 0;
        walk      = WALK_DONE;
        matching  = 0;
        remaining = '0;
        held      = '0;
        held_ok   = 0;
        errors    = 0;
    endfunction

    function void set_wanted(logic [7:0] code);
        wanted = code;
    endfunction

    function void queue_value(logic [7:0] b, logic last);
        dove_pkg::out_word_t w;
        w.value_byte = b;
        w.value_last = last;
        expected_values.push_back(w);
    endfunction

    // returns 1 when the word was walked, 0 when it was ignored
    function bit note_word(dove_pkg::in_word_t w);
        int unsigned len;
        int unsigned pos;
        logic [7:0]  b;
        b = w.opt_byte;
        if (w.first_byte)
        begin
            len = w.options_len;
            if (len > area_max)
                len = area_max;
            area_len  = len;
            position  = 0;
            walk      = WALK_CODE;
            matching  = 0;
            remaining = '0;
            held      = '0;
            held_ok   = 0;
        end
        if (walk == WALK_DONE)
            return 0;
        pos = position;
        position = pos + 1;
        case (walk)
            WALK_CODE:
            begin
                if (pos + 1 >= area_len || b == dove_pkg::CODE_END)
                    walk = WALK_DONE;
                else if (b != dove_pkg::CODE_PAD)
                begin
                    matching = (b == wanted);
                    walk = WALK_LEN;
                end
            end
            WALK_LEN:
            begin
                if (pos + 1 + int'(b) >= area_len)
                    walk = WALK_DONE;
                else if (b == 8'd0)
                    walk = WALK_CODE;
                else
                begin
                    remaining = b;
                    walk = WALK_DATA;
                end
            end
            default:
            begin
                remaining = remaining - 8'd1;
                if (matching)
                begin
                    if (remaining != 8'd0)
                    begin
                        if (held_ok)
                            queue_value(held, 1'b0);
                        held = b;
                        held_ok = 1;
                    end
                    else
                    begin
                        if (b == 8'd0)
                        begin
                            if (held_ok)
                                queue_value(held, 1'b1);
                        end
                        else
                        begin
                            if (held_ok)
                                queue_value(held, 1'b0);
                            queue_value(b, 1'b1);
                        end
                        held_ok = 0;
                        held = '0;
                    end
                end
                if (remaining == 8'd0)
                begin
                    matching = 0;
                    walk = WALK_CODE;
                end
            end
        endcase
        return 1;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("%s", msg);
    endtask

    task check_word(dove_pkg::out_word_t got);
        dove_pkg::out_word_t want;
        if (expected_values.size() == 0)
            report($sformatf("unexpected value word %h last %b",
                             got.value_byte, got.value_last));
        else
        begin
            want = expected_values.pop_front();
            if (got.value_byte != want.value_byte)
                report($sformatf("value_byte: got %h want %h",
                                 got.value_byte, want.value_byte));
            if (got.value_last != want.value_last)
                report($sformatf("value_last: got %b want %b (byte %h)",
                                 got.value_last, want.value_last, want.value_byte));
        end
    endtask

endclass

module dhcp_option_value_extractor_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dove_pkg::*;

    localparam int OPTIONS_MAX = 512;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_SETTING = 106;
    localparam int SETTLE_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_word;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    value_scoreboard sb;
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    int              sent_count = 0;
    int              cycle_count = 0;
    logic [7:0]      area_bytes[$];

    int idle_send_by_mode[4] = '{0, 76, 0, 11};
    int stall_by_mode[4]     = '{0, 0, 76, 11};

    dhcp_option_value_extractor #(
        .OPTIONS_MAX(OPTIONS_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dhcp_option_value_extractor: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(out_word);
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [9:0] len);
        in_word_t w;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        w.opt_byte    = b;
        w.first_byte  = first;
        w.options_len = len;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
        void'(sb.note_word(w));
        sent_count++;
    endtask

    task automatic send_area(input logic [9:0] olen, input int count);
        int k;
        for (k = 0; k < count; k++)
            send_byte(area_bytes[k], k == 0, (k == 0) ? olen : 10'($urandom));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wanted(input logic [7:0] code);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_wanted(code);
    endtask

    task automatic random_area(input logic [7:0] code_hint);
        int         k;
        int         j;
        int         n_opts;
        int         dlen;
        int         total;
        int         cut;
        logic [9:0] olen;
        area_bytes.delete();
        n_opts = $urandom_range(5);
        for (k = 0; k < n_opts; k++)
        begin
            if ($urandom_range(7) == 0)
                area_bytes.push_back(CODE_PAD);
            else
            begin
                area_bytes.push_back(($urandom_range(2) != 0) ? code_hint
                                                              : 8'($urandom_range(254, 1)));
                dlen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
                area_bytes.push_back(8'(dlen));
                for (j = 0; j < dlen; j++)
                    area_bytes.push_back((j == dlen - 1 && $urandom_range(3) == 0)
                                         ? 8'd0 : 8'($urandom));
            end
        end
        if ($urandom_range(4) != 0)
            area_bytes.push_back(CODE_END);
        repeat ($urandom_range(2)) area_bytes.push_back(8'($urandom));
        if (area_bytes.size() == 0)
            area_bytes.push_back(8'($urandom));
        total = area_bytes.size();
        case ($urandom_range(9))
            0: olen = 10'($urandom);
            1: olen = 10'($urandom_range(total));
            default: olen = 10'(total + $urandom_range(1));
        endcase
        cut = total;
        // area cut short by the next first byte
        if ($urandom_range(9) == 0)
            cut = $urandom_range(total, 1);
        send_area(olen, cut);
    endtask

    task automatic random_traffic();
        if ($urandom_range(14) == 0)
            repeat ($urandom_range(4, 1))
                send_byte(8'($urandom), $urandom_range(3) == 0, 10'($urandom));
        else
            random_area(sb.wanted);
    endtask

    initial
    begin
        int         mode;
        int         s;
        int         goal;
        logic [7:0] setting[4];
        sb = new(OPTIONS_MAX);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty area, ignored byte, one-byte area
        send_byte(8'd15, 1'b1, 10'd0);
        send_byte(8'd15, 1'b0, 10'h3FF);
        send_byte(8'd15, 1'b1, 10'd1);
        // oversized length, plain value, trailing nul, lone nul, zero length, pad, end
        area_bytes = '{8'd15, 8'd2, 8'h41, 8'h42, 8'd15, 8'd2, 8'h43, 8'h00,
                       8'd15, 8'd1, 8'h00, 8'd15, 8'd0, 8'h00, 8'hFF};
        send_area(10'h3FF, area_bytes.size());
        // unfinished value dropped by a new area
        area_bytes = '{8'd15, 8'd3, 8'h01};
        send_area(10'd20, area_bytes.size());
        // data that would reach the final byte, then a byte after the stop
        area_bytes = '{8'd15, 8'd5, 8'hAA};
        send_area(10'd6, area_bytes.size());

        settle();
        write_wanted(CODE_END);
        area_bytes = '{8'hFF, 8'd1, 8'h55, 8'hFF};
        send_area(10'd4, area_bytes.size());
        settle();
        write_wanted(CODE_PAD);
        area_bytes = '{8'h00, 8'h00, 8'h00, 8'd1, 8'h00, 8'hFF};
        send_area(10'd6, area_bytes.size());

        for (mode = 0; mode < 4; mode++)
        begin
            setting[0] = 8'd1;
            setting[1] = 8'd254;
            setting[2] = 8'($urandom_range(254, 1));
            setting[3] = WANTED_DEFAULT;
            for (s = 0; s < 4; s++)
            begin
                settle();
                send_idle_pct = idle_send_by_mode[mode];
                stall_pct = stall_by_mode[mode];
                write_wanted(setting[s]);
                goal = sent_count + ITEMS_PER_SETTING;
                while (sent_count < goal)
                    random_traffic();
            end
        end

        settle();
        if (sb.errors == 0)
            $display("dhcp_option_value_extractor: match");
        else
            $display("dhcp_option_value_extractor: mismatch");
        $finish;
    end

endmodule
